// ===== rtl/core/phbtm_pkg.sv =====
// ----------------------------------------------------------------------------
// Pipeline hazard and branch target timing model package
// Shared constants, instruction kind codes and word types for the timing
// model of a five-stage pipeline with a two-entry prefetch buffer.
// ----------------------------------------------------------------------------
package phbtm_pkg;

  // The branch target table size must be a power of two.
  localparam int BTB_ENTRIES  = 64;
  localparam int BTB_IDX_W    = $clog2(BTB_ENTRIES);
  localparam int INDEX_SHIFT  = 2;
  localparam int FLUSH_CYCLES = 6;
  localparam int FLUSH_W      = 3;
  localparam int NUM_SLOTS    = 7;

  localparam logic [31:0] PC_STEP     = 32'd4;
  localparam logic [31:0] CYCLE_RESET = 32'hFFFF_FFFE;

  localparam logic [3:0] KIND_NOP      = 4'd0;
  localparam logic [3:0] KIND_RTYPE    = 4'd1;
  localparam logic [3:0] KIND_ITYPE    = 4'd2;
  localparam logic [3:0] KIND_LOAD     = 4'd3;
  localparam logic [3:0] KIND_STORE    = 4'd4;
  localparam logic [3:0] KIND_BRANCH   = 4'd5;
  localparam logic [3:0] KIND_JUMP     = 4'd6;
  localparam logic [3:0] KIND_SPECIAL  = 4'd7;
  localparam logic [3:0] KIND_JREG     = 4'd8;
  localparam logic [3:0] KIND_SQUASHED = 4'd9;

  typedef struct packed {
    logic        offered_valid;
    logic [3:0]  instr_kind;
    logic [31:0] instr_pc;
    logic [7:0]  src_reg_a;
    logic [7:0]  src_reg_b;
    logic [7:0]  dest_reg;
    logic [31:0] target_addr;
  } in_word_t;

  typedef struct packed {
    logic               accepted;
    logic               finished;
    logic signed [31:0] cycle_index;
    logic [3:0]         retired_kind;
    logic [31:0]        retired_pc;
    logic [7:0]         retired_src_a;
    logic [7:0]         retired_src_b;
    logic [7:0]         retired_dest;
    logic [31:0]        retired_addr;
  } out_word_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] pc;
    logic [7:0]  src_a;
    logic [7:0]  src_b;
    logic [7:0]  dest;
    logic [31:0] addr;
  } slot_t;

  function automatic slot_t empty_slot(input logic [3:0] kind);
    slot_t s;
    s       = '0;
    s.kind  = kind;
    return s;
  endfunction

  function automatic logic [BTB_IDX_W-1:0] btb_index(input logic [31:0] pc);
    return pc[INDEX_SHIFT +: BTB_IDX_W];
  endfunction

endpackage

// ===== rtl/core/pipeline_hazard_btb_timing_model_unit.sv =====
// ----------------------------------------------------------------------------
// Pipeline hazard and branch target timing model
// Each accepted word advances a five-stage pipeline model with a prefetch
// buffer by one cycle and returns the instruction leaving writeback.
// ----------------------------------------------------------------------------
// Output: each result word is registered as its input word is accepted;
// once the trace-end drain completes, later words report only completion.
// Throughput: one word per cycle unless the output stalls; the table read for
// the next word is registered during this one, bypassing same-entry writes.
// Reset: all slots hold no-ops, the cycle counter starts at minus two, and
// the target table valid and taken bits are cleared at once.
module pipeline_hazard_btb_timing_model_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  phbtm_pkg::in_word_t in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output phbtm_pkg::out_word_t out_word
);

  localparam int NS = phbtm_pkg::NUM_SLOTS;

  logic                                predict_mode_r;
  phbtm_pkg::slot_t                    slot_r [NS];
  phbtm_pkg::slot_t                    slot_nxt [NS];
  logic                                trace_over_r, trace_over_nxt;
  logic [phbtm_pkg::FLUSH_W-1:0]       flush_left_r, flush_left_nxt;
  logic [31:0]                         cycle_count_r, cycle_count_nxt;
  logic                                done_r, done_nxt;
  logic                                out_valid_r, out_valid_nxt;
  phbtm_pkg::out_word_t                out_word_r, out_word_nxt;

  logic [phbtm_pkg::BTB_ENTRIES-1:0]   btb_vld_r, btb_tkn_r;
  logic [31:0]                         btb_mem [phbtm_pkg::BTB_ENTRIES];
  logic [31:0]                         rd_tgt_r;

  logic                                step, live, advance;
  logic                                hazard, squash, fetched, taken, finish_now;
  logic [3:0]                          k0, k1;
  logic [phbtm_pkg::BTB_IDX_W-1:0]     ix, rd_idx;
  logic                                tbl_tkn;
  logic [31:0]                         tbl_tgt;
  logic                                btb_we, btb_wtkn;

  assign in_stall  = out_valid_r & out_stall;
  assign step      = in_valid & ~in_stall;
  assign live      = step & ~done_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign k0      = slot_r[0].kind;
  assign k1      = slot_r[1].kind;
  assign ix      = phbtm_pkg::btb_index(slot_r[0].pc);
  assign taken   = slot_r[0].pc != (slot_r[1].pc - phbtm_pkg::PC_STEP);
  assign tbl_tkn = btb_tkn_r[ix];
  assign tbl_tgt = btb_vld_r[ix] ? rd_tgt_r : 32'd0;

  always_comb begin
    hazard = 1'b0;
    if (k0 == phbtm_pkg::KIND_LOAD) begin
      if (slot_r[1].src_a == slot_r[0].dest && k1 != phbtm_pkg::KIND_JUMP &&
          k1 != phbtm_pkg::KIND_SPECIAL && k1 != phbtm_pkg::KIND_SQUASHED) begin
        hazard = 1'b1;
      end
      if (slot_r[1].src_b == slot_r[0].dest && (k1 == phbtm_pkg::KIND_RTYPE ||
          k1 == phbtm_pkg::KIND_STORE || k1 == phbtm_pkg::KIND_BRANCH)) begin
        hazard = 1'b1;
      end
    end
  end

  always_comb begin
    squash   = 1'b0;
    btb_we   = 1'b0;
    btb_wtkn = 1'b1;
    if (!predict_mode_r) begin
      if (k0 == phbtm_pkg::KIND_JUMP || k0 == phbtm_pkg::KIND_JREG) begin
        squash = 1'b1;
      end else if (k0 == phbtm_pkg::KIND_BRANCH && taken) begin
        squash = 1'b1;
      end
    end else if (k0 == phbtm_pkg::KIND_BRANCH) begin
      squash   = (tbl_tkn != taken) | (taken & (tbl_tgt != slot_r[0].addr));
      btb_we   = live;
      btb_wtkn = taken;
    end else if (k0 == phbtm_pkg::KIND_JUMP || k0 == phbtm_pkg::KIND_JREG) begin
      squash = tbl_tgt != slot_r[0].addr;
      btb_we = live;
    end
  end

  always_comb begin
    fetched        = 1'b0;
    trace_over_nxt = trace_over_r;
    if (!hazard && !squash && !trace_over_r) begin
      if (in_word.offered_valid) begin
        fetched = 1'b1;
      end else begin
        trace_over_nxt = 1'b1;
      end
    end
    finish_now = trace_over_nxt && flush_left_r == '0;
    advance    = live & ~finish_now;
  end

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      slot_nxt[i] = slot_r[i];
    end
    flush_left_nxt  = flush_left_r;
    cycle_count_nxt = cycle_count_r;
    done_nxt        = done_r | (live & finish_now);
    if (advance) begin
      cycle_count_nxt = cycle_count_r + 32'd1;
      for (int i = 3; i < NS; i++) begin
        slot_nxt[i] = slot_r[i-1];
      end
      slot_nxt[2] = slot_r[0];
      if (squash) begin
        slot_nxt[0] = phbtm_pkg::empty_slot(phbtm_pkg::KIND_SQUASHED);
      end else if (hazard) begin
        slot_nxt[0] = phbtm_pkg::empty_slot(phbtm_pkg::KIND_NOP);
      end else begin
        slot_nxt[0] = slot_r[1];
      end
      if (trace_over_nxt) begin
        slot_nxt[1]    = phbtm_pkg::empty_slot(phbtm_pkg::KIND_NOP);
        flush_left_nxt = flush_left_r - 1'b1;
      end else if (fetched) begin
        slot_nxt[1].kind  = in_word.instr_kind;
        slot_nxt[1].pc    = in_word.instr_pc;
        slot_nxt[1].src_a = in_word.src_reg_a;
        slot_nxt[1].src_b = in_word.src_reg_b;
        slot_nxt[1].dest  = in_word.dest_reg;
        slot_nxt[1].addr  = in_word.target_addr;
      end
    end
  end

  always_comb begin
    out_word_nxt = '0;
    if (done_nxt) begin
      out_word_nxt.finished    = 1'b1;
      out_word_nxt.cycle_index = cycle_count_r;
    end else begin
      out_word_nxt.accepted      = fetched;
      out_word_nxt.cycle_index   = cycle_count_nxt;
      out_word_nxt.retired_kind  = slot_nxt[NS-1].kind;
      out_word_nxt.retired_pc    = slot_nxt[NS-1].pc;
      out_word_nxt.retired_src_a = slot_nxt[NS-1].src_a;
      out_word_nxt.retired_src_b = slot_nxt[NS-1].src_b;
      out_word_nxt.retired_dest  = slot_nxt[NS-1].dest;
      out_word_nxt.retired_addr  = slot_nxt[NS-1].addr;
    end
    if (step) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r & out_stall;
    end
  end

  assign rd_idx = phbtm_pkg::btb_index(slot_nxt[0].pc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      predict_mode_r <= 1'b0;
      for (int i = 0; i < NS; i++) begin
        slot_r[i] <= phbtm_pkg::empty_slot(phbtm_pkg::KIND_NOP);
      end
      trace_over_r  <= 1'b0;
      flush_left_r  <= phbtm_pkg::FLUSH_W'(phbtm_pkg::FLUSH_CYCLES);
      cycle_count_r <= phbtm_pkg::CYCLE_RESET;
      done_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      btb_vld_r     <= '0;
      btb_tkn_r     <= '0;
    end else begin
      if (cfg_we) begin
        predict_mode_r <= cfg_wdata;
      end
      if (advance) begin
        for (int i = 0; i < NS; i++) begin
          slot_r[i] <= slot_nxt[i];
        end
        flush_left_r  <= flush_left_nxt;
        cycle_count_r <= cycle_count_nxt;
      end
      if (live) begin
        trace_over_r <= trace_over_nxt;
      end
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
      if (btb_we) begin
        btb_vld_r[ix] <= 1'b1;
        btb_tkn_r[ix] <= btb_wtkn;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_word_r <= out_word_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (btb_we) begin
      btb_mem[ix] <= slot_r[0].addr;
    end
    if (btb_we && ix == rd_idx) begin
      rd_tgt_r <= slot_r[0].addr;
    end else begin
      rd_tgt_r <= btb_mem[rd_idx];
    end
  end

  property p_done_holds;
    @(posedge clk) disable iff (!rst_n) done_r |=> done_r;
  endproperty
  a_done_holds: assert property (p_done_holds) else $error("completion flag dropped");

  property p_finish_not_accepted;
    @(posedge clk) disable iff (!rst_n)
      (out_valid_r && out_word_r.finished) |-> !out_word_r.accepted;
  endproperty
  a_finish_not_accepted: assert property (p_finish_not_accepted)
    else $error("finished word reports an accepted instruction");

  property p_flush_idle;
    @(posedge clk) disable iff (!rst_n)
      !trace_over_r |-> flush_left_r == phbtm_pkg::FLUSH_W'(phbtm_pkg::FLUSH_CYCLES);
  endproperty
  a_flush_idle: assert property (p_flush_idle) else $error("drain count moved before trace end");

  property p_no_fetch_on_bubble;
    @(posedge clk) disable iff (!rst_n) (live && (hazard || squash)) |-> !fetched;
  endproperty
  a_no_fetch_on_bubble: assert property (p_no_fetch_on_bubble)
    else $error("instruction fetched during a stall or squash");

  property p_cycle_advance;
    @(posedge clk) disable iff (!rst_n)
      advance |=> cycle_count_r == $past(cycle_count_r) + 32'd1;
  endproperty
  a_cycle_advance: assert property (p_cycle_advance) else $error("cycle counter did not advance");

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Pipeline hazard and branch target timing model testbench
// Streams trace words into the timing model under random idling and
// back-pressure. A cycle-accurate predictor built into this file works out
// every result word, and each result word is checked field by field against
// it. The run covers load-use stalls, both prediction modes, squashed slots
// and, at the very end, the trace-end drain and the finished state.
// ----------------------------------------------------------------------------
module tb;

  localparam logic       MODE_NOT_TAKEN = 1'b0;
  localparam logic       MODE_TABLE     = 1'b1;
  localparam logic [3:0] KIND_MAX       = 4'hF;
  localparam int         IDLE_PCT       = 23;
  localparam int         MAX_REPORTS    = 10;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic                 cfg_wdata = 1'b0;
  logic                 in_valid  = 1'b0;
  phbtm_pkg::in_word_t  in_word   = '0;
  logic                 out_stall = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  phbtm_pkg::out_word_t out_word;

  pipeline_hazard_btb_timing_model_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always #1 clk = ~clk;

  logic                          predict_mode;
  phbtm_pkg::slot_t              pipe [phbtm_pkg::NUM_SLOTS];
  logic [phbtm_pkg::FLUSH_W-1:0] flush_left;
  logic                          trace_over;
  logic                          done_flag;
  logic [31:0]                   cycle_count;
  logic                          btb_taken [phbtm_pkg::BTB_ENTRIES];
  logic [31:0]                   btb_target [phbtm_pkg::BTB_ENTRIES];

  phbtm_pkg::out_word_t expected_retire [$];
  int        fail_count  = 0;
  int        idle_pct    = IDLE_PCT;
  int        hold_cycles = 0;

  logic [31:0] trace_pc;
  logic [31:0] region_base;
  logic [7:0]  load_dest;
  logic        load_pending = 1'b0;

  function automatic void reset_model();
    predict_mode = MODE_NOT_TAKEN;
    for (int i = 0; i < phbtm_pkg::NUM_SLOTS; i++) begin
      pipe[i] = '0;
      pipe[i].kind = phbtm_pkg::KIND_NOP;
    end
    flush_left  = phbtm_pkg::FLUSH_W'(phbtm_pkg::FLUSH_CYCLES);
    trace_over  = 1'b0;
    done_flag   = 1'b0;
    cycle_count = phbtm_pkg::CYCLE_RESET;
    for (int i = 0; i < phbtm_pkg::BTB_ENTRIES; i++) begin
      btb_taken[i]  = 1'b0;
      btb_target[i] = '0;
    end
  endfunction

  function automatic phbtm_pkg::out_word_t advance_pipeline(input phbtm_pkg::in_word_t w);
    phbtm_pkg::out_word_t            r;
    logic                            hazard;
    logic                            squash;
    logic                            fetched;
    logic                            taken;
    logic [3:0]                      k0;
    logic [3:0]                      k1;
    logic [phbtm_pkg::BTB_IDX_W-1:0] ix;
    r       = '0;
    hazard  = 1'b0;
    squash  = 1'b0;
    fetched = 1'b0;
    k0      = pipe[0].kind;
    k1      = pipe[1].kind;
    taken   = (pipe[0].pc != pipe[1].pc - phbtm_pkg::PC_STEP);
    ix      = phbtm_pkg::BTB_IDX_W'((pipe[0].pc >> phbtm_pkg::INDEX_SHIFT) %
                                    phbtm_pkg::BTB_ENTRIES);
    if (!done_flag) begin
      if (k0 == phbtm_pkg::KIND_LOAD) begin
        if (pipe[1].src_a == pipe[0].dest && k1 != phbtm_pkg::KIND_JUMP &&
            k1 != phbtm_pkg::KIND_SPECIAL && k1 != phbtm_pkg::KIND_SQUASHED)
          hazard = 1'b1;
        if (pipe[1].src_b == pipe[0].dest &&
            (k1 == phbtm_pkg::KIND_RTYPE || k1 == phbtm_pkg::KIND_STORE ||
             k1 == phbtm_pkg::KIND_BRANCH))
          hazard = 1'b1;
      end
      if (predict_mode == MODE_NOT_TAKEN) begin
        squash = (k0 == phbtm_pkg::KIND_JUMP || k0 == phbtm_pkg::KIND_JREG ||
                  (k0 == phbtm_pkg::KIND_BRANCH && taken));
      end else if (k0 == phbtm_pkg::KIND_BRANCH) begin
        squash = (btb_taken[ix] != taken) || (taken && btb_target[ix] != pipe[0].addr);
        btb_taken[ix]  = taken;
        btb_target[ix] = pipe[0].addr;
      end else if (k0 == phbtm_pkg::KIND_JUMP || k0 == phbtm_pkg::KIND_JREG) begin
        squash = (btb_target[ix] != pipe[0].addr);
        btb_taken[ix]  = 1'b1;
        btb_target[ix] = pipe[0].addr;
      end
      if (!hazard && !squash && !trace_over) begin
        if (w.offered_valid)
          fetched = 1'b1;
        else
          trace_over = 1'b1;
      end
      if (trace_over && flush_left == '0)
        done_flag = 1'b1;
    end

    if (done_flag) begin
      r.finished    = 1'b1;
      r.cycle_index = cycle_count;
      return r;
    end

    cycle_count = cycle_count + 32'd1;
    for (int s = phbtm_pkg::NUM_SLOTS - 1; s >= 3; s--)
      pipe[s] = pipe[s-1];
    pipe[2] = pipe[0];
    if (squash) begin
      pipe[0] = '0;
      pipe[0].kind = phbtm_pkg::KIND_SQUASHED;
    end else if (hazard) begin
      pipe[0] = '0;
      pipe[0].kind = phbtm_pkg::KIND_NOP;
    end else begin
      pipe[0] = pipe[1];
    end
    if (trace_over) begin
      pipe[1] = '0;
      pipe[1].kind = phbtm_pkg::KIND_NOP;
      flush_left = flush_left - 1'b1;
    end else if (fetched) begin
      pipe[1] = {w.instr_kind, w.instr_pc, w.src_reg_a, w.src_reg_b, w.dest_reg,
                 w.target_addr};
    end

    r.accepted      = fetched;
    r.cycle_index   = cycle_count;
    r.retired_kind  = pipe[6].kind;
    r.retired_pc    = pipe[6].pc;
    r.retired_src_a = pipe[6].src_a;
    r.retired_src_b = pipe[6].src_b;
    r.retired_dest  = pipe[6].dest;
    r.retired_addr  = pipe[6].addr;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      expected_retire.push_back(advance_pipeline(in_word));
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      if (fail_count < MAX_REPORTS)
        $display("mismatch on %s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    phbtm_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_retire.size() == 0) begin
        if (fail_count < MAX_REPORTS)
          $display("unexpected result word %h", out_word);
        fail_count++;
      end else begin
        want = expected_retire.pop_front();
        check_field("accepted", want.accepted, out_word.accepted);
        check_field("finished", want.finished, out_word.finished);
        check_field("cycle_index", want.cycle_index, out_word.cycle_index);
        check_field("retired_kind", want.retired_kind, out_word.retired_kind);
        check_field("retired_pc", want.retired_pc, out_word.retired_pc);
        check_field("retired_src_a", want.retired_src_a, out_word.retired_src_a);
        check_field("retired_src_b", want.retired_src_b, out_word.retired_src_b);
        check_field("retired_dest", want.retired_dest, out_word.retired_dest);
        check_field("retired_addr", want.retired_addr, out_word.retired_addr);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  task automatic send_word(input phbtm_pkg::in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_retire.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_mode(input logic mode);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
    predict_mode = mode;
  endtask

  function automatic phbtm_pkg::in_word_t instr(input logic [3:0] kind,
                                                input logic [31:0] pc,
                                                input logic [7:0] a, input logic [7:0] b,
                                                input logic [7:0] d,
                                                input logic [31:0] addr);
    phbtm_pkg::in_word_t w;
    w = {1'b1, kind, pc, a, b, d, addr};
    return w;
  endfunction

  // Mostly a well-formed trace: sequential PCs inside a small region so that
  // table entries are revisited, with loads often feeding the next word.
  function automatic phbtm_pkg::in_word_t make_instr();
    phbtm_pkg::in_word_t w;
    int                  pick;
    int                  reg_max;
    logic [31:0]         next_pc;
    w = '0;
    w.offered_valid = 1'b1;
    w.instr_pc = trace_pc;
    reg_max = ($urandom_range(99) < 10) ? 255 : 7;
    w.src_reg_a = 8'($urandom_range(reg_max));
    w.src_reg_b = 8'($urandom_range(reg_max));
    w.dest_reg  = 8'($urandom_range(reg_max));
    w.target_addr = ($urandom_range(99) < 5) ? $urandom
                    : region_base + phbtm_pkg::PC_STEP * $urandom_range(31);
    pick = $urandom_range(99);
    if (pick < 18)      w.instr_kind = phbtm_pkg::KIND_LOAD;
    else if (pick < 30) w.instr_kind = phbtm_pkg::KIND_RTYPE;
    else if (pick < 38) w.instr_kind = phbtm_pkg::KIND_ITYPE;
    else if (pick < 46) w.instr_kind = phbtm_pkg::KIND_STORE;
    else if (pick < 60) w.instr_kind = phbtm_pkg::KIND_BRANCH;
    else if (pick < 68) w.instr_kind = phbtm_pkg::KIND_JUMP;
    else if (pick < 74) w.instr_kind = phbtm_pkg::KIND_JREG;
    else if (pick < 78) w.instr_kind = phbtm_pkg::KIND_SPECIAL;
    else if (pick < 83) w.instr_kind = phbtm_pkg::KIND_NOP;
    else if (pick < 87) w.instr_kind = phbtm_pkg::KIND_SQUASHED;
    else if (pick < 91)
      w.instr_kind = 4'($urandom_range(KIND_MAX, phbtm_pkg::KIND_SQUASHED + 4'd1));
    else                w.instr_kind = phbtm_pkg::KIND_RTYPE;
    if (load_pending && $urandom_range(99) < 60) begin
      if ($urandom_range(1))
        w.src_reg_a = load_dest;
      else
        w.src_reg_b = load_dest;
    end
    load_pending = (w.instr_kind == phbtm_pkg::KIND_LOAD);
    load_dest    = w.dest_reg;
    case (w.instr_kind)
      phbtm_pkg::KIND_BRANCH:
        next_pc = $urandom_range(1) ? w.target_addr : trace_pc + phbtm_pkg::PC_STEP;
      phbtm_pkg::KIND_JUMP, phbtm_pkg::KIND_JREG: next_pc = w.target_addr;
      default: next_pc = trace_pc + phbtm_pkg::PC_STEP;
    endcase
    if ($urandom_range(99) < 3)
      next_pc = $urandom;
    trace_pc = next_pc;
    return w;
  endfunction

  task automatic run_trace(input int count);
    phbtm_pkg::in_word_t w;
    region_base = $urandom & ~32'h3;
    trace_pc    = region_base;
    repeat (count) begin
      w = make_instr();
      send_word(w);
      if ($urandom_range(99) < 20)
        send_word(w);
    end
  endtask

  task automatic test_directed_not_taken();
    set_mode(MODE_NOT_TAKEN);
    send_word(instr(phbtm_pkg::KIND_NOP, '0, '0, '0, '0, '0));
    send_word('1);
    send_word(instr(phbtm_pkg::KIND_LOAD, 32'h100, 8'd1, 8'd2, 8'd5, 32'h40));
    send_word(instr(phbtm_pkg::KIND_RTYPE, 32'h104, 8'd9, 8'd5, 8'd3, 32'h0));
    send_word(instr(phbtm_pkg::KIND_RTYPE, 32'h104, 8'd9, 8'd5, 8'd3, 32'h0));
    send_word(instr(phbtm_pkg::KIND_LOAD, 32'h108, 8'd0, 8'd0, 8'd6, 32'h44));
    send_word(instr(phbtm_pkg::KIND_ITYPE, 32'h10C, 8'd1, 8'd6, 8'd2, 32'h0));
    send_word(instr(phbtm_pkg::KIND_LOAD, 32'h110, 8'd0, 8'd0, 8'd6, 32'h48));
    send_word(instr(phbtm_pkg::KIND_ITYPE, 32'h114, 8'd6, 8'd0, 8'd2, 32'h0));
    send_word(instr(phbtm_pkg::KIND_ITYPE, 32'h114, 8'd6, 8'd0, 8'd2, 32'h0));
    send_word(instr(phbtm_pkg::KIND_LOAD, 32'h118, 8'd0, 8'd0, 8'd7, 32'h0));
    send_word(instr(phbtm_pkg::KIND_JUMP, 32'h11C, 8'd7, 8'd7, 8'd0, 32'h200));
    send_word(instr(phbtm_pkg::KIND_RTYPE, 32'h200, 8'd1, 8'd2, 8'd3, 32'h0));
    send_word(instr(phbtm_pkg::KIND_BRANCH, 32'h204, 8'd1, 8'd2, 8'd0, 32'h300));
    send_word(instr(phbtm_pkg::KIND_RTYPE, 32'h300, 8'd1, 8'd2, 8'd3, 32'h0));
    send_word(instr(phbtm_pkg::KIND_BRANCH, 32'h304, 8'd1, 8'd2, 8'd0, 32'h400));
    send_word(instr(phbtm_pkg::KIND_ITYPE, 32'h308, 8'd1, 8'd2, 8'd3, 32'h0));
    send_word(instr(phbtm_pkg::KIND_JREG, 32'h30C, 8'd4, 8'd0, 8'd0, 32'h500));
    send_word(instr(phbtm_pkg::KIND_STORE, 32'h500, 8'd1, 8'd2, 8'd0, 32'h80));
    send_word(instr(phbtm_pkg::KIND_SPECIAL, 32'h504, 8'd3, 8'd3, 8'd3, 32'h0));
    send_word(instr(phbtm_pkg::KIND_SQUASHED, 32'h508, 8'd1, 8'd1, 8'd1, 32'h0));
    send_word(instr(phbtm_pkg::KIND_SQUASHED + 4'd3, 32'h50C, 8'd2, 8'd2, 8'd2,
                    32'h0));
  endtask

  task automatic test_directed_table();
    set_mode(MODE_TABLE);
    repeat (3) begin
      send_word(instr(phbtm_pkg::KIND_BRANCH, 32'h600, 8'd1, 8'd2, 8'd0, 32'h700));
      send_word(instr(phbtm_pkg::KIND_RTYPE, 32'h700, 8'd1, 8'd2, 8'd3, 32'h0));
      send_word(instr(phbtm_pkg::KIND_JUMP, 32'h704, 8'd0, 8'd0, 8'd0, 32'h600));
    end
    send_word(instr(phbtm_pkg::KIND_BRANCH, 32'h600, 8'd1, 8'd2, 8'd0, 32'h700));
    send_word(instr(phbtm_pkg::KIND_ITYPE, 32'h604, 8'd1, 8'd2, 8'd3, 32'h0));
    send_word(instr(phbtm_pkg::KIND_JREG, 32'h608, 8'd5, 8'd0, 8'd0, 32'h704));
    send_word(instr(phbtm_pkg::KIND_NOP, 32'h704, 8'd0, 8'd0, 8'd0, 32'h0));
  endtask

  task automatic test_random_not_taken();
    set_mode(MODE_NOT_TAKEN);
    run_trace(150);
  endtask

  task automatic test_random_table();
    set_mode(MODE_TABLE);
    run_trace(150);
  endtask

  task automatic test_no_idle();
    idle_pct = 0;
    run_trace(120);
    idle_pct = IDLE_PCT;
  endtask

  task automatic test_backpressure();
    set_mode(MODE_NOT_TAKEN);
    hold_cycles = 80;
    run_trace(40);
  endtask

  task automatic test_mode_flips();
    for (int i = 0; i < 4; i++) begin
      set_mode(i[0] ? MODE_NOT_TAKEN : MODE_TABLE);
      run_trace(25);
    end
  endtask

  // The end mark right behind a load-use pair is refused at first and offered
  // again; once the drain completes, later words only report completion.
  task automatic test_trace_end();
    phbtm_pkg::in_word_t w;
    set_mode(MODE_TABLE);
    send_word(instr(phbtm_pkg::KIND_LOAD, 32'h900, 8'd0, 8'd0, 8'd3, 32'h0));
    send_word(instr(phbtm_pkg::KIND_RTYPE, 32'h904, 8'd3, 8'd1, 8'd2, 32'h0));
    repeat (4) begin
      w = make_instr();
      w.offered_valid = 1'b0;
      send_word(w);
    end
    repeat (16) send_word(make_instr());
  endtask

  initial begin
    reset_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_not_taken();
    test_directed_table();
    test_random_not_taken();
    test_random_table();
    test_no_idle();
    test_backpressure();
    test_mode_flips();
    test_trace_end();
    in_valid <= 1'b0;
    for (int n = 0; n < 2000 && expected_retire.size() != 0; n++)
      @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0 && expected_retire.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== pipeline_hazard_btb_timing_model_unit.f =====
rtl/core/phbtm_pkg.sv
rtl/core/pipeline_hazard_btb_timing_model_unit.sv
tb/sv/tb.sv
